### rtl/poldeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package poldeg_pkg;

	localparam int PIX_W            = 16;
	localparam int DEPTH_W          = 5;
	localparam int STATUS_W         = 2;
	localparam int ANGLE_FRAC_BITS  = 14;
	localparam int CORDIC_STEPS     = 24;
	localparam int TABLE_SCALE_BITS = 30;
	localparam int TABLE_DROP       = TABLE_SCALE_BITS - ANGLE_FRAC_BITS;
	localparam int RATIO_W          = PIX_W + 1;
	localparam int SQRT_W           = RATIO_W;
	localparam int SQRT_IN_W        = 2 * SQRT_W - 1;
	localparam int XY_SHIFT         = 8;
	localparam int XY_W             = SQRT_W + XY_SHIFT + 3;
	localparam int ANG_W            = ANGLE_FRAC_BITS + 4;
	localparam int PIPE_LAT         = RATIO_W + SQRT_W + CORDIC_STEPS + 1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SUM  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_DEPTH = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

	localparam longint ATAN_TABLE [CORDIC_STEPS] = '{
		1073741824, 633866811, 334917815, 170009512, 85334662, 42708931,
		21359677, 10680490, 5340327, 2670173, 1335088, 667544,
		333772, 166886, 83443, 41722, 20861, 10430,
		5215, 2608, 1304, 652, 326, 163
	};

	typedef struct packed {
		logic [PIX_W-1:0] upper_left_pixel;
		logic [PIX_W-1:0] upper_right_pixel;
		logic [PIX_W-1:0] lower_left_pixel;
		logic [PIX_W-1:0] lower_right_pixel;
	} cell_t;

	typedef struct packed {
		logic [PIX_W-1:0]    polarization_degree;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DEPTH_W-1:0]  depth;
	} info_t;

	function automatic logic signed [ANG_W-1:0] step_angle(input int i);
		longint t;
		t = (ATAN_TABLE[i] + (longint'(1) << (TABLE_DROP - 1))) >>> TABLE_DROP;
		return ANG_W'(t);
	endfunction

	function automatic logic depth_ok(input logic [DEPTH_W-1:0] d);
		return d inside {5'd8, 5'd10, 5'd12, 5'd14, 5'd16};
	endfunction

endpackage
`default_nettype wire

### rtl/poldeg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module poldeg_div (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire logic [poldeg_pkg::PIX_W-1:0]   num,
	input  wire logic [poldeg_pkg::RATIO_W-1:0] den,
	output logic      [poldeg_pkg::RATIO_W-1:0] ratio
);
	import poldeg_pkg::*;

	logic [RATIO_W:0]   rem_s [RATIO_W];
	logic [RATIO_W-1:0] quo_s [RATIO_W];
	logic [RATIO_W-1:0] den_s [RATIO_W];

	for (genvar k = 0; k < RATIO_W; k++) begin : g_step
		logic [RATIO_W:0]   rem_in;
		logic [RATIO_W-1:0] den_in;
		logic [RATIO_W-1:0] quo_in;
		logic               ge;

		if (k == 0) begin : g_first
			assign rem_in = (RATIO_W + 1)'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = {rem_s[k-1][RATIO_W-1:0], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign ge = rem_in >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? rem_in - {1'b0, den_in} : rem_in;
				quo_s[k] <= quo_in | (RATIO_W'(ge) << (RATIO_W - 1 - k));
				den_s[k] <= den_in;
			end
		end
	end

	assign ratio = quo_s[RATIO_W-1];

endmodule
`default_nettype wire

### rtl/poldeg_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module poldeg_isqrt (
	input  wire logic                            clk,
	input  wire logic                            adv,
	input  wire logic [poldeg_pkg::SQRT_IN_W-1:0] val,
	output logic      [poldeg_pkg::SQRT_W-1:0]    root
);
	import poldeg_pkg::*;

	logic [SQRT_IN_W-1:0] v_s   [SQRT_W];
	logic [SQRT_IN_W:0]   res_s [SQRT_W];

	for (genvar j = 0; j < SQRT_W; j++) begin : g_step
		localparam logic [SQRT_IN_W:0] BIT = (SQRT_IN_W + 1)'(1) << (2 * (SQRT_W - 1 - j));
		logic [SQRT_IN_W-1:0] v_in;
		logic [SQRT_IN_W:0]   res_in;
		logic [SQRT_IN_W:0]   trial;
		logic                 ge;

		if (j == 0) begin : g_first
			assign v_in   = val;
			assign res_in = '0;
		end else begin : g_next
			assign v_in   = v_s[j-1];
			assign res_in = res_s[j-1];
		end

		assign trial = res_in + BIT;
		assign ge    = {1'b0, v_in} >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				v_s[j]   <= ge ? SQRT_IN_W'({1'b0, v_in} - trial) : v_in;
				res_s[j] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
			end
		end
	end

	assign root = res_s[SQRT_W-1][SQRT_W-1:0];

endmodule
`default_nettype wire

### rtl/poldeg_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module poldeg_cordic (
	input  wire logic                                 clk,
	input  wire logic                                 adv,
	input  wire logic signed [poldeg_pkg::XY_W-1:0]   x_in,
	input  wire logic signed [poldeg_pkg::XY_W-1:0]   y_in,
	output logic      signed [poldeg_pkg::ANG_W-1:0]  angle
);
	import poldeg_pkg::*;

	logic signed [XY_W-1:0]  x_s [CORDIC_STEPS];
	logic signed [XY_W-1:0]  y_s [CORDIC_STEPS];
	logic signed [ANG_W-1:0] z_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ANG_W-1:0] STEP = step_angle(i);
		logic signed [XY_W-1:0]  x_c;
		logic signed [XY_W-1:0]  y_c;
		logic signed [ANG_W-1:0] z_c;
		logic signed [XY_W-1:0]  xs;
		logic signed [XY_W-1:0]  ys;

		if (i == 0) begin : g_first
			assign x_c = x_in;
			assign y_c = y_in;
			assign z_c = '0;
		end else begin : g_next
			assign x_c = x_s[i-1];
			assign y_c = y_s[i-1];
			assign z_c = z_s[i-1];
		end

		assign xs = x_c >>> i;
		assign ys = y_c >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_c > 0) begin
					x_s[i] <= x_c + ys;
					y_s[i] <= y_c - xs;
					z_s[i] <= z_c + STEP;
				end else begin
					x_s[i] <= x_c - ys;
					y_s[i] <= y_c + xs;
					z_s[i] <= z_c - STEP;
				end
			end
		end
	end

	assign angle = z_s[CORDIC_STEPS-1];

endmodule
`default_nettype wire

### rtl/polarization_degree_2x2.sv
// channel   direction  payload            handshake
// pixel     in         cell_t (4 x 16b)   pixel_valid / pixel_stall
// result    out        result_t (16b+2b)  result_valid / result_stall
// config    in         5b bit_depth       cfg_we / cfg_data
//
// One 2x2 cell per cycle unless result_stall holds the result register.
// The pipeline runs a 17-step divider, 17-step square root and 24-step CORDIC.
// All stages advance together whenever the result register is empty or taken.
// pixel_stall follows result_stall while a result is held.
// Reset clears valid bits and sets bit_depth to 8.
`timescale 1ns / 1ps
`default_nettype none
module polarization_degree_2x2 (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pixel_valid,
	output logic                                   pixel_stall,
	input  wire poldeg_pkg::cell_t                 pixel,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output poldeg_pkg::result_t                    result,
	input  wire logic                              cfg_we,
	input  wire logic [poldeg_pkg::DEPTH_W-1:0]     cfg_data
);
	import poldeg_pkg::*;

	localparam logic signed [ANG_W-1:0] Q_ANG  = ANG_W'(1) << ANGLE_FRAC_BITS;
	localparam logic signed [ANG_W-1:0] Q2_ANG = ANG_W'(2) << ANGLE_FRAC_BITS;
	localparam int SC_W = ANGLE_FRAC_BITS + 1 + 32;

	logic [DEPTH_W-1:0] bit_depth_q;
	logic               adv;
	logic               vld_s  [PIPE_LAT];
	info_t              info_s [PIPE_LAT];
	info_t              info_c;
	logic               depth_q;

	logic [RATIO_W-1:0] sum_a, sum_b, ratio_a, ratio_b;
	logic [SQRT_W-1:0]  cos_a, sin_a, cos_b, sin_b;
	logic signed [ANG_W-1:0] za, zb, a, b, r1, r2, d, d_s, val;
	logic [SC_W-1:0]    scaled, maxv;

	assign adv         = !result_valid || !result_stall;
	assign pixel_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			bit_depth_q <= cfg_data;
		end
	end

	assign sum_a = RATIO_W'(pixel.upper_left_pixel) + RATIO_W'(pixel.lower_right_pixel);
	assign sum_b = RATIO_W'(pixel.upper_right_pixel) + RATIO_W'(pixel.lower_left_pixel);

	always_comb begin
		info_c.depth = bit_depth_q;
		if (!depth_ok(bit_depth_q)) begin
			info_c.status = STATUS_BAD_DEPTH;
		end else if (sum_a == '0 || sum_b == '0) begin
			info_c.status = STATUS_ZERO_SUM;
		end else begin
			info_c.status = STATUS_OK;
		end
	end

	for (genvar k = 0; k < PIPE_LAT; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= (k == 0) ? pixel_valid : vld_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				info_s[k] <= (k == 0) ? info_c : info_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	poldeg_div u_div_a (.clk, .adv, .num(pixel.upper_left_pixel), .den(sum_a), .ratio(ratio_a));
	poldeg_div u_div_b (.clk, .adv, .num(pixel.upper_right_pixel), .den(sum_b), .ratio(ratio_b));

	poldeg_isqrt u_cos_a (.clk, .adv, .val({ratio_a, 16'b0}), .root(cos_a));
	poldeg_isqrt u_sin_a (.clk, .adv, .val({RATIO_W'(17'd65536 - ratio_a), 16'b0}), .root(sin_a));
	poldeg_isqrt u_cos_b (.clk, .adv, .val({ratio_b, 16'b0}), .root(cos_b));
	poldeg_isqrt u_sin_b (.clk, .adv, .val({RATIO_W'(17'd65536 - ratio_b), 16'b0}), .root(sin_b));

	poldeg_cordic u_cordic_a (
		.clk, .adv,
		.x_in(XY_W'({cos_a, 8'b0})), .y_in(XY_W'({sin_a, 8'b0})), .angle(za)
	);
	poldeg_cordic u_cordic_b (
		.clk, .adv,
		.x_in(XY_W'({cos_b, 8'b0})), .y_in(XY_W'({sin_b, 8'b0})), .angle(zb)
	);

	always_comb begin
		a = (za < 0) ? '0 : (za > Q2_ANG) ? Q2_ANG : za;
		b = (zb < 0) ? '0 : (zb > Q2_ANG) ? Q2_ANG : zb;
		r1 = (b > Q_ANG) ? -a : a;
		if (a < Q_ANG) begin
			r2 = Q_ANG - b;
		end else if (b <= Q_ANG) begin
			r2 = Q_ANG + b;
		end else begin
			r2 = b - (Q_ANG + Q2_ANG);
		end
		d = (r1 - r2 < 0) ? r2 - r1 : r1 - r2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s <= d;
		end
	end

	always_comb begin
		val    = Q_ANG - d_s;
		scaled = (SC_W'(val[ANGLE_FRAC_BITS:0]) << info_s[PIPE_LAT-1].depth) >> ANGLE_FRAC_BITS;
		maxv   = (SC_W'(1) << info_s[PIPE_LAT-1].depth) - SC_W'(1);
		if (scaled > maxv) begin
			scaled = maxv;
		end
		if (val <= 0 || info_s[PIPE_LAT-1].status != STATUS_OK) begin
			scaled = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.polarization_degree <= scaled[PIX_W-1:0];
			result.status              <= info_s[PIPE_LAT-1].status;
			depth_q                    <= (info_s[PIPE_LAT-1].depth == 5'd16);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid)
		else $error("input stalled with empty result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STATUS_OK |-> result.polarization_degree == '0)
		else $error("flagged result carries nonzero degree");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == STATUS_OK || result.status == STATUS_ZERO_SUM
			|| result.status == STATUS_BAD_DEPTH)
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !depth_q && result.status == STATUS_OK
			|-> result.polarization_degree != 16'hFFFF)
		else $error("degree exceeds depth range");

endmodule
`default_nettype wire

### verif/tb_polarization_degree_2x2.sv
`timescale 1ns / 1ps
module tb_polarization_degree_2x2;
	import poldeg_pkg::*;

	localparam int DRAIN_CYCLES = PIPE_LAT + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	cell_t pixel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [DEPTH_W-1:0] cfg_data = '0;

	logic [DEPTH_W-1:0] depth_model = DEPTH_RESET;
	result_t expected_degrees[$];
	int errors = 0;
	bit quiet_period = 1'b0;

	polarization_degree_2x2 dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint shift_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 32;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint diagonal_angle(longint unsigned num, longint unsigned total);
		longint unsigned r;
		longint x, y, z, xs, ys, step, top;
		r = (num << 16) / total;
		z = 0;
		top = longint'(2) << ANGLE_FRAC_BITS;
		if (r > 65536)
			r = 65536;
		x = int_sqrt(r << 16) * 256;
		y = int_sqrt((65536 - r) << 16) * 256;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = shift_floor(x, i);
			ys = shift_floor(y, i);
			step = (ATAN_TABLE[i] + (longint'(1) << (TABLE_DROP - 1))) >>> TABLE_DROP;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + step;
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - step;
			end
		end
		if (z < 0)
			z = 0;
		if (z > top)
			z = top;
		return z;
	endfunction

	function automatic result_t predict_degree(cell_t c, logic [DEPTH_W-1:0] depth);
		result_t res;
		longint ul, ur, ll, lr, q, a, b, r1, r2, d, val, maxv;
		ul = c.upper_left_pixel;
		ur = c.upper_right_pixel;
		ll = c.lower_left_pixel;
		lr = c.lower_right_pixel;
		q = longint'(1) << ANGLE_FRAC_BITS;
		res = '0;
		if (!(depth == 8 || depth == 10 || depth == 12 || depth == 14 || depth == 16)) begin
			res.status = STATUS_BAD_DEPTH;
			return res;
		end
		if (ul + lr == 0 || ur + ll == 0) begin
			res.status = STATUS_ZERO_SUM;
			return res;
		end
		a = diagonal_angle(ul, ul + lr);
		b = diagonal_angle(ur, ur + ll);
		r1 = (b > q) ? -a : a;
		if (a < q)
			r2 = q - b;
		else if (b <= q)
			r2 = q + b;
		else
			r2 = q + b - 4 * q;
		d = r1 - r2;
		if (d < 0)
			d = -d;
		val = q - d;
		maxv = (longint'(1) << depth) - 1;
		if (val <= 0) begin
			val = 0;
		end else begin
			val = (val << depth) >>> ANGLE_FRAC_BITS;
			if (val > maxv)
				val = maxv;
		end
		res.polarization_degree = val[PIX_W-1:0];
		res.status = STATUS_OK;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit idle_now();
		return !quiet_period && ($urandom_range(99) < 36);
	endfunction

	task automatic send_cell(cell_t c);
		while (idle_now()) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel <= c;
		pixel_valid <= 1'b1;
		expected_degrees.push_back(predict_degree(c, depth_model));
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		pixel_valid <= 1'b0;
		while (expected_degrees.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_depth(logic [DEPTH_W-1:0] depth);
		wait_drained();
		cfg_data <= depth;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		depth_model = depth;
	endtask

	function automatic cell_t random_cell();
		cell_t c;
		int mode;
		mode = $urandom_range(9);
		c.upper_left_pixel = 16'($urandom);
		c.upper_right_pixel = 16'($urandom);
		c.lower_left_pixel = 16'($urandom);
		c.lower_right_pixel = 16'($urandom);
		if (mode < 3) begin
			c.upper_left_pixel = 16'($urandom_range(255));
			c.upper_right_pixel = 16'($urandom_range(255));
			c.lower_left_pixel = 16'($urandom_range(255));
			c.lower_right_pixel = 16'($urandom_range(255));
		end else if (mode == 3) begin
			c.upper_right_pixel = c.upper_left_pixel + 16'($urandom_range(15));
			c.lower_left_pixel = c.lower_right_pixel + 16'($urandom_range(15));
		end else if (mode == 4) begin
			if ($urandom_range(1)) begin
				c.upper_left_pixel = '0;
				c.lower_right_pixel = '0;
			end else begin
				c.upper_right_pixel = '0;
				c.lower_left_pixel = '0;
			end
		end else if (mode == 5) begin
			c.lower_right_pixel = '0;
			c.lower_left_pixel = 16'($urandom_range(3));
		end
		return c;
	endfunction

	task automatic test_extremes();
		send_cell('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_cell('{16'd0, 16'd0, 16'd0, 16'd0});
		send_cell('{16'd0, 16'd5, 16'd5, 16'd0});
		send_cell('{16'd5, 16'd0, 16'd0, 16'd5});
		send_cell('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
		send_cell('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
		send_cell('{16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
		send_cell('{16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
		send_cell('{16'd100, 16'd100, 16'd100, 16'd100});
		send_cell('{16'd1, 16'd3, 16'd1, 16'd3});
		send_cell('{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA});
		send_cell('{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555});
		send_cell('{16'd1000, 16'd1, 16'd1000, 16'd1});
	endtask

	task automatic test_depths();
		logic [DEPTH_W-1:0] depths[9] = '{5'd16, 5'd10, 5'd0, 5'd12, 5'd31, 5'd14, 5'd9,
			5'd8, 5'd16};
		foreach (depths[k]) begin
			write_depth(depths[k]);
			send_cell('{16'hFFFF, 16'd1, 16'd7, 16'd3});
			send_cell('{16'd0, 16'd0, 16'd4, 16'd4});
			repeat (10) send_cell(random_cell());
		end
	endtask

	task automatic test_random_stream();
		logic [DEPTH_W-1:0] depths[5] = '{5'd8, 5'd12, 5'd16, 5'd10, 5'd14};
		foreach (depths[k]) begin
			write_depth(depths[k]);
			quiet_period = (k == 2);
			repeat (200) send_cell(random_cell());
		end
		quiet_period = 1'b0;
	endtask

	initial begin
		forever begin
			@(negedge clk);
			result_stall <= idle_now();
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_degrees.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				exp_res = expected_degrees.pop_front();
				if (result.polarization_degree !== exp_res.polarization_degree)
					report_mismatch($sformatf("degree %0d, expected %0d",
						result.polarization_degree, exp_res.polarization_degree));
				if (result.status !== exp_res.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, exp_res.status));
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_depths();
		test_random_stream();
		wait_drained();
		if (expected_degrees.size() != 0)
			report_mismatch("expected results left over");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
